// File: rtl/core/s38i_pkg.sv
package s38i_pkg;

  // field widths
  localparam int unsigned LIMIT_W = 24;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned RESULT_W = 64;
  localparam int unsigned STATUS_W = 2;

  // largest interval count that is accepted
  localparam int unsigned MAX_INTERVALS = 4095;

  // fixed-point layout
  localparam int unsigned QSHIFT = 24;                  // Q.12 limit -> Q.36 point
  localparam int unsigned DVD_W = LIMIT_W + QSHIFT;     // |b-a| * 2^24 plus rounding
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);
  localparam int unsigned X_W = 52;                     // Q.36 sample point
  localparam int unsigned U_W = X_W - 12;               // Q.24 magnitude of x+1
  localparam int unsigned UL_W = 24;
  localparam int unsigned UH_W = U_W - UL_W;
  localparam int unsigned F_W = 57;                     // f(x) in Q.24
  localparam int unsigned TERM_W = F_W + 2;
  localparam int unsigned SUM_W = 64;
  localparam int unsigned H3_W = DVD_W + 1;
  localparam int unsigned MA_W = 32;
  localparam int unsigned MB_W = 26;
  localparam int unsigned P_W = MA_W + MB_W;
  localparam int unsigned ACC_W = 128;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

  // microprogram steps
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CHECK = 4'd1;
  localparam logic [STEP_W-1:0] STEP_DIVW = 4'd2;
  localparam logic [STEP_W-1:0] STEP_POINT = 4'd3;
  localparam logic [STEP_W-1:0] STEP_DRAIN0 = 4'd4;
  localparam logic [STEP_W-1:0] STEP_DRAIN1 = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DRAIN2 = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DRAIN3 = 4'd7;
  localparam logic [STEP_W-1:0] STEP_FIN0 = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FIN1 = 4'd9;
  localparam logic [STEP_W-1:0] STEP_FIN2 = 4'd10;
  localparam logic [STEP_W-1:0] STEP_FIN3 = 4'd11;
  localparam logic [STEP_W-1:0] STEP_FIN4 = 4'd12;
  localparam logic [STEP_W-1:0] STEP_OUT = 4'd13;

  typedef enum logic [2:0] {
    COND_NEXT     = 3'd0,
    COND_WAIT_IN  = 3'd1,
    COND_BAD      = 3'd2,
    COND_WAIT_DIV = 3'd3,
    COND_LOOP_PT  = 3'd4,
    COND_OUT_FREE = 3'd5,
    COND_JUMP     = 3'd6
  } cond_t;

  typedef enum logic [1:0] {
    MUL_LO_LO = 2'd0,
    MUL_LO_HI = 2'd1,
    MUL_HI_LO = 2'd2,
    MUL_HI_HI = 2'd3
  } mul_part_t;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_INIT = 2'd1,
    ACC_ADD  = 2'd2
  } acc_op_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_26 = 2'd1,
    SH_32 = 2'd2,
    SH_58 = 2'd3
  } acc_shift_t;

  typedef enum logic [1:0] {
    W_NONE  = 2'd0,
    W_ONE   = 2'd1,
    W_TWO   = 2'd2,
    W_THREE = 2'd3
  } weight_t;

  typedef struct packed {
    logic       in_ready;
    logic       div_start;
    logic       pt_init;
    logic       pt_issue;
    logic       mul_en;
    mul_part_t  mul_part;
    acc_op_t    acc_op;
    acc_shift_t acc_shift;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic accepted;
    logic bad;
    logic div_busy;
    logic last_pt;
    logic out_free;
  } stat_t;

  typedef struct packed {
    cond_t             cond;
    logic [STEP_W-1:0] target;
    ctrl_t             ctrl;
  } uword_t;

  // control store
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    w = '0;
    case (step)
      STEP_IDLE: begin
        w.cond = COND_WAIT_IN;
        w.ctrl.in_ready = 1'b1;
      end
      STEP_CHECK: begin
        w.cond = COND_BAD;
        w.target = STEP_OUT;
        w.ctrl.div_start = 1'b1;
        w.ctrl.pt_init = 1'b1;
      end
      STEP_DIVW: begin
        w.cond = COND_WAIT_DIV;
      end
      STEP_POINT: begin
        w.cond = COND_LOOP_PT;
        w.ctrl.pt_issue = 1'b1;
      end
      STEP_DRAIN0, STEP_DRAIN1, STEP_DRAIN2, STEP_DRAIN3: begin
        w.cond = COND_NEXT;
      end
      STEP_FIN0: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_part = MUL_LO_LO;
        w.ctrl.acc_op = ACC_INIT;
      end
      STEP_FIN1: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_part = MUL_LO_HI;
        w.ctrl.acc_op = ACC_ADD;
        w.ctrl.acc_shift = SH_0;
      end
      STEP_FIN2: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_part = MUL_HI_LO;
        w.ctrl.acc_op = ACC_ADD;
        w.ctrl.acc_shift = SH_26;
      end
      STEP_FIN3: begin
        w.ctrl.mul_en = 1'b1;
        w.ctrl.mul_part = MUL_HI_HI;
        w.ctrl.acc_op = ACC_ADD;
        w.ctrl.acc_shift = SH_32;
      end
      STEP_FIN4: begin
        w.ctrl.acc_op = ACC_ADD;
        w.ctrl.acc_shift = SH_58;
      end
      STEP_OUT: begin
        w.cond = COND_OUT_FREE;
        w.target = STEP_IDLE;
        w.ctrl.out_load = 1'b1;
      end
      default: begin
        w.cond = COND_JUMP;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // remainder by three: base-4 digit sum, folded twice
  function automatic logic [1:0] mod3_count(input logic [COUNT_W-1:0] v);
    logic [4:0] s;
    logic [2:0] s2;
    logic [2:0] s3;
    s = '0;
    for (int k = 0; k < COUNT_W / 2; k++) begin
      s = s + {3'd0, v[2*k +: 2]};
    end
    s2 = s[4:2] + {1'b0, s[1:0]};
    s3 = {2'd0, s2[2]} + {1'b0, s2[1:0]};
    if (s3 >= 3'd3) begin
      return 2'(s3 - 3'd3);
    end
    return s3[1:0];
  endfunction

endpackage

// File: rtl/core/s38i_in_if.sv
interface s38i_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [s38i_pkg::LIMIT_W-1:0] lower_limit;
  logic signed [s38i_pkg::LIMIT_W-1:0] upper_limit;
  logic [s38i_pkg::COUNT_W-1:0]        interval_count;

  modport source (output valid, output lower_limit, output upper_limit,
                  output interval_count, input ready);
  modport sink (input valid, input lower_limit, input upper_limit,
                input interval_count, output ready);
endinterface

// File: rtl/core/s38i_out_if.sv
interface s38i_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [s38i_pkg::RESULT_W-1:0] integral;
  logic [s38i_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output integral, output status, input ready);
  modport sink (input valid, input integral, input status, output ready);
endinterface

// File: rtl/core/s38i_div.sv
module s38i_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [s38i_pkg::DVD_W-1:0]     dividend,
  input  logic [s38i_pkg::COUNT_W-1:0]   divisor,
  output logic                           busy,
  output logic [s38i_pkg::DVD_W-1:0]     quotient
);

  localparam logic [s38i_pkg::DIV_CNT_W-1:0] CNT_LOAD =
    s38i_pkg::DIV_CNT_W'(s38i_pkg::DVD_W - 1);

  logic [s38i_pkg::COUNT_W-1:0]   rem;
  logic [s38i_pkg::DVD_W-1:0]     dq;
  logic [s38i_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy_r;
  logic [s38i_pkg::COUNT_W:0]     trial;
  logic [s38i_pkg::COUNT_W:0]     trial_sub;
  logic                           fits;

  // restoring divide, one quotient bit per cycle
  assign trial = {rem, dq[s38i_pkg::DVD_W-1]};
  assign trial_sub = trial - {1'b0, divisor};
  assign fits = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && (cnt == '0)) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq <= dividend;
      cnt <= CNT_LOAD;
    end else if (busy_r) begin
      rem <= fits ? trial_sub[s38i_pkg::COUNT_W-1:0] : trial[s38i_pkg::COUNT_W-1:0];
      dq <= {dq[s38i_pkg::DVD_W-2:0], fits};
      cnt <= cnt - 1'b1;
    end
  end

  assign busy = busy_r;
  assign quotient = dq;

endmodule

// File: rtl/core/s38i_seq.sv
module s38i_seq (
  input  logic              clk,
  input  logic              rst,
  input  s38i_pkg::stat_t   stat,
  output s38i_pkg::ctrl_t   ctrl
);

  logic [s38i_pkg::STEP_W-1:0] step;
  logic [s38i_pkg::STEP_W-1:0] step_next;
  logic [s38i_pkg::STEP_W-1:0] step_inc;
  s38i_pkg::uword_t            word;

  assign word = s38i_pkg::ucode(step);
  assign ctrl = word.ctrl;
  assign step_inc = step + 1'b1;

  always_comb begin
    case (word.cond)
      s38i_pkg::COND_NEXT:     step_next = step_inc;
      s38i_pkg::COND_WAIT_IN:  step_next = stat.accepted ? step_inc : step;
      s38i_pkg::COND_BAD:      step_next = stat.bad ? word.target : step_inc;
      s38i_pkg::COND_WAIT_DIV: step_next = stat.div_busy ? step : step_inc;
      s38i_pkg::COND_LOOP_PT:  step_next = stat.last_pt ? step_inc : step;
      s38i_pkg::COND_OUT_FREE: step_next = stat.out_free ? word.target : step;
      s38i_pkg::COND_JUMP:     step_next = word.target;
      default:                 step_next = s38i_pkg::STEP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= s38i_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// File: rtl/core/s38i_dp.sv
module s38i_dp (
  input  logic             clk,
  input  logic             rst,
  input  s38i_pkg::ctrl_t  ctrl,
  output s38i_pkg::stat_t  stat,
  s38i_in_if.sink          req,
  s38i_out_if.source       rsp
);

  localparam int unsigned LW = s38i_pkg::LIMIT_W;
  localparam int unsigned CW = s38i_pkg::COUNT_W;
  localparam int unsigned XW = s38i_pkg::X_W;
  localparam int unsigned DW = s38i_pkg::DVD_W;
  localparam logic [XW-1:0] Y_BIAS = XW'((64'd1 << 11) + (64'd1 << 36));
  localparam logic [s38i_pkg::ACC_W-1:0] ACC_ROUND = s38i_pkg::ACC_W'(1) << 62;
  localparam logic [s38i_pkg::RESULT_W-1:0] INT_MAX = {1'b0, {(s38i_pkg::RESULT_W-1){1'b1}}};

  // captured item
  logic [LW-1:0] a_r;
  logic [LW-1:0] b_r;
  logic [CW-1:0] n_r;

  // step width
  logic [LW:0]   diff;
  logic [LW:0]   diff_mag;
  logic          neg;
  logic [DW-1:0] dividend;
  logic [DW-1:0] hm;
  logic          div_busy;
  logic          bad;
  logic [XW-1:0] h_pos;
  logic [XW-1:0] h36;
  logic [XW-1:0] a36;
  logic [XW-1:0] b36;

  // point generator
  logic [XW-1:0]       x;
  logic [CW-1:0]       idx;
  logic [1:0]          m3;
  logic                last;
  logic [XW-1:0]       x_pt;
  s38i_pkg::weight_t   w0;

  // pipeline
  logic [XW-1:0]                 ysum;
  logic [s38i_pkg::U_W-1:0]      y;
  logic [s38i_pkg::U_W-1:0]      umag;
  logic [s38i_pkg::U_W-1:0]      u1;
  logic [s38i_pkg::UH_W-1:0]     uh;
  logic [s38i_pkg::UL_W-1:0]     ul;
  logic [2*s38i_pkg::UH_W-1:0]   p_hh;
  logic [s38i_pkg::UH_W+s38i_pkg::UL_W-1:0] p_hl;
  logic [s38i_pkg::P_W-1:0]      p_ll;
  logic [s38i_pkg::MA_W-1:0]     mul_a;
  logic [s38i_pkg::MB_W-1:0]     mul_b;
  logic [s38i_pkg::F_W-1:0]      f;
  logic [s38i_pkg::TERM_W-1:0]   term;
  logic [s38i_pkg::SUM_W:0]      sum_add;
  logic [s38i_pkg::SUM_W-1:0]    sum;
  logic                          sat;
  s38i_pkg::weight_t             w1;
  s38i_pkg::weight_t             w2;
  s38i_pkg::weight_t             w3;
  s38i_pkg::weight_t             w4;

  // final scale
  logic [s38i_pkg::H3_W-1:0]     hm3;
  logic [s38i_pkg::MB_W-1:0]     hm3_lo;
  logic [s38i_pkg::MB_W-1:0]     hm3_hi;
  logic [s38i_pkg::ACC_W-1:0]    acc;
  logic [s38i_pkg::ACC_W-1:0]    addend;
  logic [s38i_pkg::RESULT_W-1:0] rmag;
  logic [s38i_pkg::RESULT_W-1:0] res_val;
  logic [s38i_pkg::STATUS_W-1:0] res_st;

  // output register
  logic                          out_valid;
  logic                          out_free;
  logic [s38i_pkg::RESULT_W-1:0] integral_r;
  logic [s38i_pkg::STATUS_W-1:0] status_r;

  assign req.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_r <= req.lower_limit;
      b_r <= req.upper_limit;
      n_r <= req.interval_count;
    end
  end

  assign diff = {b_r[LW-1], b_r} - {a_r[LW-1], a_r};
  assign neg = diff[LW];
  assign diff_mag = neg ? (~diff + 1'b1) : diff;
  assign dividend = {diff_mag[LW-1:0], {s38i_pkg::QSHIFT{1'b0}}}
                  + {{(DW-CW+1){1'b0}}, n_r[CW-1:1]};

  assign bad = (n_r == '0) || (s38i_pkg::mod3_count(n_r) != 2'd0)
            || ({20'd0, n_r} > s38i_pkg::MAX_INTERVALS);

  s38i_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (dividend),
    .divisor  (n_r),
    .busy     (div_busy),
    .quotient (hm)
  );

  assign h_pos = {{(XW-DW){1'b0}}, hm};
  assign h36 = neg ? (~h_pos + 1'b1) : h_pos;
  assign a36 = {{(XW-LW-s38i_pkg::QSHIFT){a_r[LW-1]}}, a_r, {s38i_pkg::QSHIFT{1'b0}}};
  assign b36 = {{(XW-LW-s38i_pkg::QSHIFT){b_r[LW-1]}}, b_r, {s38i_pkg::QSHIFT{1'b0}}};

  // sample points by repeated add of h; the far end uses b exactly
  assign last = idx == n_r;
  assign x_pt = last ? b36 : x;

  always_comb begin
    if ((idx == '0) || last) begin
      w0 = s38i_pkg::W_ONE;
    end else if (m3 == 2'd0) begin
      w0 = s38i_pkg::W_TWO;
    end else begin
      w0 = s38i_pkg::W_THREE;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pt_init) begin
      x <= a36;
      idx <= '0;
      m3 <= 2'd0;
    end else if (ctrl.pt_issue) begin
      x <= x + h36;
      idx <= idx + 1'b1;
      m3 <= (m3 == 2'd2) ? 2'd0 : m3 + 2'd1;
    end
  end

  // weight codes travel with the point, none marks a bubble
  always_ff @(posedge clk) begin
    if (rst) begin
      w1 <= s38i_pkg::W_NONE;
      w2 <= s38i_pkg::W_NONE;
      w3 <= s38i_pkg::W_NONE;
      w4 <= s38i_pkg::W_NONE;
    end else begin
      w1 <= ctrl.pt_issue ? w0 : s38i_pkg::W_NONE;
      w2 <= w1;
      w3 <= w2;
      w4 <= w3;
    end
  end

  // stage 1: round to Q.24, add one, take magnitude
  assign ysum = x_pt + Y_BIAS;
  assign y = ysum[XW-1:12];
  assign umag = y[s38i_pkg::U_W-1] ? (~y + 1'b1) : y;

  always_ff @(posedge clk) begin
    u1 <= umag;
  end

  // stage 2: partial squares, shared multiplier also serves the final scale
  assign uh = u1[s38i_pkg::U_W-1:s38i_pkg::UL_W];
  assign ul = u1[s38i_pkg::UL_W-1:0];
  assign hm3 = {1'b0, hm} + {hm, 1'b0};
  assign hm3_lo = hm3[s38i_pkg::MB_W-1:0];
  assign hm3_hi = {{(2*s38i_pkg::MB_W-s38i_pkg::H3_W){1'b0}},
                   hm3[s38i_pkg::H3_W-1:s38i_pkg::MB_W]};

  always_comb begin
    if (ctrl.mul_en) begin
      case (ctrl.mul_part)
        s38i_pkg::MUL_LO_LO: begin
          mul_a = sum[31:0];
          mul_b = hm3_lo;
        end
        s38i_pkg::MUL_LO_HI: begin
          mul_a = sum[31:0];
          mul_b = hm3_hi;
        end
        s38i_pkg::MUL_HI_LO: begin
          mul_a = sum[63:32];
          mul_b = hm3_lo;
        end
        s38i_pkg::MUL_HI_HI: begin
          mul_a = sum[63:32];
          mul_b = hm3_hi;
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end else begin
      mul_a = {{(s38i_pkg::MA_W-s38i_pkg::UL_W){1'b0}}, ul};
      mul_b = {{(s38i_pkg::MB_W-s38i_pkg::UL_W){1'b0}}, ul};
    end
  end

  always_ff @(posedge clk) begin
    p_hh <= uh * uh;
    p_hl <= uh * ul;
    p_ll <= mul_a * mul_b;
  end

  // stage 3: floor(u^2 / 2^24)
  always_ff @(posedge clk) begin
    f <= {1'b0, p_hh, 24'd0} + {16'd0, p_hl, 1'b0} + {23'd0, p_ll[s38i_pkg::P_W-1:24]};
  end

  // stage 4: weight by shift and add
  always_ff @(posedge clk) begin
    case (w3)
      s38i_pkg::W_ONE:   term <= {2'b0, f};
      s38i_pkg::W_TWO:   term <= {1'b0, f, 1'b0};
      s38i_pkg::W_THREE: term <= {2'b0, f} + {1'b0, f, 1'b0};
      default:           term <= '0;
    endcase
  end

  // stage 5: saturating accumulate
  assign sum_add = {1'b0, sum} + {{(s38i_pkg::SUM_W+1-s38i_pkg::TERM_W){1'b0}}, term};

  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (ctrl.pt_init) begin
      sat <= 1'b0;
    end else if ((w4 != s38i_pkg::W_NONE) && sum_add[s38i_pkg::SUM_W]) begin
      sat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pt_init) begin
      sum <= '0;
    end else if (w4 != s38i_pkg::W_NONE) begin
      sum <= sum_add[s38i_pkg::SUM_W] ? '1 : sum_add[s38i_pkg::SUM_W-1:0];
    end
  end

  // sum * 3h plus rounding half, from four partial products
  always_comb begin
    case (ctrl.acc_shift)
      s38i_pkg::SH_0:  addend = {70'd0, p_ll};
      s38i_pkg::SH_26: addend = {44'd0, p_ll, 26'd0};
      s38i_pkg::SH_32: addend = {38'd0, p_ll, 32'd0};
      s38i_pkg::SH_58: addend = {12'd0, p_ll, 58'd0};
      default:         addend = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      s38i_pkg::ACC_INIT: acc <= ACC_ROUND;
      s38i_pkg::ACC_ADD:  acc <= acc + addend;
      default:            acc <= acc;
    endcase
  end

  assign rmag = acc[126:63];

  always_comb begin
    if (bad) begin
      res_val = '0;
      res_st = s38i_pkg::ST_BAD_COUNT;
    end else if (hm == '0) begin
      res_val = '0;
      res_st = s38i_pkg::ST_OK;
    end else if (sat || (acc[127:126] != 2'd0)) begin
      res_val = neg ? (~INT_MAX + 1'b1) : INT_MAX;
      res_st = s38i_pkg::ST_SAT;
    end else begin
      res_val = neg ? (~rmag + 1'b1) : rmag;
      res_st = s38i_pkg::ST_OK;
    end
  end

  // result register
  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load && out_free) begin
      integral_r <= res_val;
      status_r <= res_st;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.integral = integral_r;
  assign rsp.status = status_r;

  assign stat.accepted = req.valid && req.ready;
  assign stat.bad = bad;
  assign stat.div_busy = div_busy;
  assign stat.last_pt = last;
  assign stat.out_free = out_free;

endmodule

// File: rtl/core/simpson_three_eighths_integrator_unit.sv
// one item in work at a time; a good count passes the step divide, then one sample point
//   per cycle through the point pipeline, while a bad count goes straight to the result
// reset: synchronous, active high; clears the step counter, pipeline tokens and result valid
module simpson_three_eighths_integrator_unit (
  input  logic        clk,
  input  logic        rst,
  s38i_in_if.sink     req,
  s38i_out_if.source  rsp
);

  // control word from the microprogram, and the flags it branches on
  s38i_pkg::ctrl_t ctrl;
  s38i_pkg::stat_t stat;

  // sequencer walks the control store:
  //   idle    wait for a beat on req
  //   check   start the step divide, seed the point generator, branch out on bad count
  //   divw    hold until the quotient settles
  //   point   issue one sample point a cycle until the far end goes in
  //   drain   wait out the pipeline until the last weighted term lands in the sum
  //   fin     four partial products of sum * 3h into the wide accumulator
  //   out     load the result register once it is free, then back to idle
  s38i_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctrl (ctrl)
  );

  // datapath: capture, divider, five-stage point pipeline, scale and result register
  // the result register parts the two sides, so a waiting beat on rsp
  // does not hold off the next beat on req
  s38i_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat),
    .req  (req),
    .rsp  (rsp)
  );

endmodule
